[hdl/acpc_pkg.sv]
package acpc_pkg;

    // Width of the tick counter and of every tick time derived from it.
    localparam int unsigned TICK_W = 32;

    localparam int unsigned PERCENT_W = 7;
    localparam int unsigned LIMIT_W   = 7;
    localparam int unsigned PHASE_W   = 7;
    localparam int unsigned ACC_W     = 8;
    localparam int unsigned DELAY_W   = 8;
    localparam int unsigned ROT_W     = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 8;

    localparam logic [PHASE_W-1:0] PHASE_WRAP   = 7'd90;
    localparam logic [ACC_W-1:0]   PERCENT_FULL = 8'd100;

    // Event kinds carried on s_tuser.
    localparam logic CMD_TICK       = 1'b0;
    localparam logic CMD_ZERO_CROSS = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 1'b1;

    localparam logic [DELAY_W-1:0] SWITCH_DELAY_RESET = 8'd0;
    localparam logic [ROT_W-1:0]   ROTATION_RESET     = 2'd2;

    typedef struct packed {
        logic                 command;
        logic [PERCENT_W-1:0] heater_percent;
        logic [LIMIT_W-1:0]   fan_phase_limit;
    } acpc_event_t;

    typedef struct packed {
        logic heater;
        logic fan;
    } acpc_levels_t;

endpackage

[hdl/acpc_core.sv]
module acpc_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  acpc_pkg::acpc_event_t         evt,
    input  logic [acpc_pkg::DELAY_W-1:0]  switch_delay,
    input  logic [acpc_pkg::ROT_W-1:0]    rotation,
    output acpc_pkg::acpc_levels_t        levels_next
);

    logic [acpc_pkg::PHASE_W-1:0] phase_count_reg, phase_count_next;
    logic [acpc_pkg::TICK_W-1:0]  tick_count_reg, tick_count_next;
    logic [acpc_pkg::TICK_W-1:0]  last_switch_reg, last_switch_next;
    logic [acpc_pkg::TICK_W-1:0]  switch_at_reg, switch_at_next;
    logic [acpc_pkg::ACC_W-1:0]   heater_acc_reg, heater_acc_next;
    logic                         heater_skip_reg, heater_skip_next;
    logic                         channel_reg, channel_next;
    logic                         heater_level_reg, heater_level_next;
    logic                         fan_level_reg, fan_level_next;

    logic [acpc_pkg::PHASE_W-1:0] phase_inc;
    logic [acpc_pkg::ACC_W-1:0]   acc_sum;

    assign phase_inc = phase_count_reg + 1'b1;
    assign acc_sum   = heater_acc_reg + acpc_pkg::ACC_W'(evt.heater_percent);

    always_comb
    begin
        phase_count_next  = phase_count_reg;
        tick_count_next   = tick_count_reg;
        last_switch_next  = last_switch_reg;
        switch_at_next    = switch_at_reg;
        heater_acc_next   = heater_acc_reg;
        heater_skip_next  = heater_skip_reg;
        channel_next      = channel_reg;
        heater_level_next = heater_level_reg;
        fan_level_next    = fan_level_reg;

        if (evt.command == acpc_pkg::CMD_ZERO_CROSS)
        begin
            phase_count_next = '0;
            if (!channel_reg)
            begin
                if (acc_sum >= acpc_pkg::PERCENT_FULL)
                begin
                    heater_acc_next  = acc_sum - acpc_pkg::PERCENT_FULL;
                    heater_skip_next = 1'b0;
                end
                else
                begin
                    heater_acc_next  = acc_sum;
                    heater_skip_next = 1'b1;
                end
                switch_at_next = tick_count_reg + acpc_pkg::TICK_W'(switch_delay);
            end
            // A rotation of two or three alternates channels, zero or one stays on the heater.
            channel_next = rotation[1] ? ~channel_reg : 1'b0;
        end
        else
        begin
            phase_count_next = (phase_inc > acpc_pkg::PHASE_WRAP) ? '0 : phase_inc;
            fan_level_next   = (phase_count_next <= evt.fan_phase_limit);
            if (switch_at_reg > last_switch_reg && tick_count_reg > switch_at_reg)
            begin
                heater_level_next = ~heater_skip_reg;
                last_switch_next  = tick_count_reg;
            end
            tick_count_next = tick_count_reg + 1'b1;
        end
    end

    assign levels_next.heater = heater_level_next;
    assign levels_next.fan    = fan_level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg  <= '0;
            tick_count_reg   <= '0;
            last_switch_reg  <= '0;
            switch_at_reg    <= '0;
            heater_acc_reg   <= '0;
            heater_skip_reg  <= 1'b0;
            channel_reg      <= 1'b0;
            heater_level_reg <= 1'b0;
            fan_level_reg    <= 1'b1;
        end
        else if (en)
        begin
            phase_count_reg  <= phase_count_next;
            tick_count_reg   <= tick_count_next;
            last_switch_reg  <= last_switch_next;
            switch_at_reg    <= switch_at_next;
            heater_acc_reg   <= heater_acc_next;
            heater_skip_reg  <= heater_skip_next;
            channel_reg      <= channel_next;
            heater_level_reg <= heater_level_next;
            fan_level_reg    <= fan_level_next;
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_count_reg <= acpc_pkg::PHASE_WRAP)
        else $error("phase counter beyond wrap point");

    a_zc_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        en && evt.command == acpc_pkg::CMD_ZERO_CROSS |=> phase_count_reg == '0)
        else $error("zero crossing did not clear phase counter");

    a_zc_keeps_levels: assert property (@(posedge clk) disable iff (!rst_n)
        en && evt.command == acpc_pkg::CMD_ZERO_CROSS
        |=> $stable(heater_level_reg) && $stable(fan_level_reg)
            && $stable(tick_count_reg) && $stable(last_switch_reg))
        else $error("zero crossing changed drive levels or tick state");

endmodule

[hdl/ac_burst_and_phase_power_control_top.sv]
// AC mains power control for one heater and one fan. Each input transaction is an
// event: s_tuser low is a timer tick, s_tuser high is a mains zero crossing. Every
// event yields exactly one output transaction with the heater and fan drive levels
// after that event. The heater uses burst firing: on zero crossings that serve the
// heater channel an accumulator adds heater_percent and, on reaching 100, drops 100
// to mark a full on-cycle; the switch takes effect on the first timer tick more than
// switch_delay ticks after the crossing. The fan uses phase-angle control: a phase
// counter clears on each zero crossing, counts timer ticks and wraps after 90, and
// the fan is driven while the counter is at or below fan_phase_limit. Zero crossings
// never change the drive levels. The block takes one event per clock while results
// are read: all state is updated together and the result lands in one output
// register, so a new transaction is accepted whenever that register is empty or
// is being read in the same cycle; the result appears in the cycle after acceptance.
// Configuration (register 0 switch_delay, register 1 channels_in_rotation) is
// accepted in every cycle and should be written while no events are in flight.
module ac_burst_and_phase_power_control_top (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [6:0] heater_percent, [13:7] fan_phase_limit, [15:14] zero
    input  logic [acpc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] command (0 = timer tick, 1 = zero crossing)
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] heater_drive, [1] fan_drive, [7:2] zero
    output logic [acpc_pkg::M_TDATA_W-1:0]    m_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [acpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [acpc_pkg::DELAY_W-1:0]      cfg_data
);

    logic [acpc_pkg::DELAY_W-1:0] switch_delay_reg;
    logic [acpc_pkg::ROT_W-1:0]   rotation_reg;

    logic                         m_tvalid_reg;
    acpc_pkg::acpc_levels_t       levels_reg;
    acpc_pkg::acpc_levels_t       levels_next;
    acpc_pkg::acpc_event_t        evt;
    logic                         s_accept;

    // The result register is free when empty or when its transaction completes now.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign evt.command         = s_tuser;
    assign evt.heater_percent  = s_tdata[acpc_pkg::PERCENT_W-1:0];
    assign evt.fan_phase_limit = s_tdata[acpc_pkg::PERCENT_W +: acpc_pkg::LIMIT_W];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_delay_reg <= acpc_pkg::SWITCH_DELAY_RESET;
            rotation_reg     <= acpc_pkg::ROTATION_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                acpc_pkg::CFG_SWITCH_DELAY: switch_delay_reg <= cfg_data;
                acpc_pkg::CFG_ROTATION:     rotation_reg <= cfg_data[acpc_pkg::ROT_W-1:0];
                default:                    ;
            endcase
        end
    end

    acpc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (s_accept),
        .evt          (evt),
        .switch_delay (switch_delay_reg),
        .rotation     (rotation_reg),
        .levels_next  (levels_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            levels_reg <= levels_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(acpc_pkg::M_TDATA_W - 2){1'b0}}, levels_reg.fan, levels_reg.heater};

    a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(s_accept))
        else $error("result appeared without an accepted event");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_tvalid_reg)
        else $error("accepted event produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !m_tready |-> !s_accept)
        else $error("pending result overwritten");

endmodule

[bench/ac_burst_and_phase_power_control_checker.sv]
module ac_burst_and_phase_power_control_checker (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [6:0] heater_percent, [13:7] fan_phase_limit, [15:14] zero
    input  logic [acpc_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command (0 = timer tick, 1 = zero crossing)
    input  logic                           s_tuser,

    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] heater_drive, [1] fan_drive, [7:2] zero
    input  logic [acpc_pkg::M_TDATA_W-1:0] m_tdata,

    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [acpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [acpc_pkg::DELAY_W-1:0]   cfg_data,

    output int                             mismatches,
    output int                             outstanding,
    output int                             event_count,
    output int                             crossing_count,
    output int                             switch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the controller state and its two registers.
    logic [acpc_pkg::DELAY_W-1:0] delay_cfg;
    logic [acpc_pkg::ROT_W-1:0]   rot_cfg;
    logic [acpc_pkg::PHASE_W-1:0] phase_cnt;
    logic [acpc_pkg::TICK_W-1:0]  tick_now;
    logic [acpc_pkg::TICK_W-1:0]  switched_at;
    logic [acpc_pkg::TICK_W-1:0]  switch_due;
    logic [acpc_pkg::ACC_W-1:0]   burst_acc;
    logic                         burst_skip;
    logic                         serve_fan;
    logic                         heater_on;
    logic                         fan_on;

    acpc_pkg::acpc_levels_t levels_due[$];
    int                     result_idx;

    // Applies one event to the shadow state and returns the drive levels after it.
    function automatic acpc_pkg::acpc_levels_t advance_levels(input acpc_pkg::acpc_event_t ev);
        acpc_pkg::acpc_levels_t lv;
        if (ev.command == acpc_pkg::CMD_ZERO_CROSS) begin
            phase_cnt = '0;
            if (!serve_fan) begin
                burst_acc = burst_acc + acpc_pkg::ACC_W'(ev.heater_percent);
                if (burst_acc >= acpc_pkg::PERCENT_FULL) begin
                    burst_acc  = burst_acc - acpc_pkg::PERCENT_FULL;
                    burst_skip = 1'b0;
                end else begin
                    burst_skip = 1'b1;
                end
                switch_due = tick_now + acpc_pkg::TICK_W'(delay_cfg);
            end
            serve_fan = (rot_cfg >= 2'd2) ? ~serve_fan : 1'b0;
            crossing_count++;
        end else begin
            phase_cnt = phase_cnt + 1'b1;
            if (phase_cnt > acpc_pkg::PHASE_WRAP)
                phase_cnt = '0;
            fan_on = (phase_cnt <= ev.fan_phase_limit);
            if (switch_due > switched_at && tick_now > switch_due) begin
                heater_on   = ~burst_skip;
                switched_at = tick_now;
                switch_count++;
            end
            tick_now = tick_now + 1'b1;
        end
        lv.heater = heater_on;
        lv.fan    = fan_on;
        return lv;
    endfunction

    function automatic void note_mismatch(input string msg);
        if (mismatches < 10)
            $display("MISMATCH at %0t: result %0d: %s", $realtime, result_idx, msg);
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        acpc_pkg::acpc_event_t  ev;
        acpc_pkg::acpc_levels_t due;
        if (!rst_n) begin
            delay_cfg      = acpc_pkg::SWITCH_DELAY_RESET;
            rot_cfg        = acpc_pkg::ROTATION_RESET;
            phase_cnt      = '0;
            tick_now       = '0;
            switched_at    = '0;
            switch_due     = '0;
            burst_acc      = '0;
            burst_skip     = 1'b0;
            serve_fan      = 1'b0;
            heater_on      = 1'b0;
            fan_on         = 1'b1;
            mismatches     = 0;
            event_count    = 0;
            crossing_count = 0;
            switch_count   = 0;
            result_idx     = 0;
            levels_due.delete();
            outstanding <= 0;
        end else begin
            // A result leaves in the cycle after its event at the earliest, so the
            // oldest expectation is retired before this cycle's event is added.
            if (m_tvalid && m_tready) begin
                if (levels_due.size() == 0) begin
                    note_mismatch($sformatf("result with none expected, tdata 0x%02h", m_tdata));
                end else begin
                    due = levels_due.pop_front();
                    if (m_tdata[0] !== due.heater)
                        note_mismatch($sformatf("heater_drive expected %0b, got %0b",
                                                due.heater, m_tdata[0]));
                    if (m_tdata[1] !== due.fan)
                        note_mismatch($sformatf("fan_drive expected %0b, got %0b",
                                                due.fan, m_tdata[1]));
                end
                result_idx++;
            end

            // An event taken at the same edge as a register write still sees
            // the old register value.
            if (s_tvalid && s_tready) begin
                ev.command         = s_tuser;
                ev.heater_percent  = s_tdata[acpc_pkg::PERCENT_W-1:0];
                ev.fan_phase_limit = s_tdata[acpc_pkg::PERCENT_W +: acpc_pkg::LIMIT_W];
                levels_due.push_back(advance_levels(ev));
                event_count++;
            end

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == acpc_pkg::CFG_SWITCH_DELAY)
                    delay_cfg = cfg_data;
                else if (cfg_index == acpc_pkg::CFG_ROTATION)
                    rot_cfg = cfg_data[acpc_pkg::ROT_W-1:0];
            end

            outstanding <= levels_due.size();
        end
    end

endmodule

[bench/ac_burst_and_phase_power_control_top_tb.sv]
module ac_burst_and_phase_power_control_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted transaction on any channel before the run is
    // declared hung. The longest legitimate quiet stretch comes from random
    // receiver or sender idling, so this is far beyond any correct run.
    localparam int STALL_LIMIT = 4000;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic [acpc_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                             s_tuser   = 1'b0;
    logic                             m_tready  = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic [acpc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [acpc_pkg::DELAY_W-1:0]     cfg_data  = '0;

    logic                             s_tready;
    logic                             m_tvalid;
    logic [acpc_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_ready;

    int fail_count;
    int outstanding;
    int event_count;
    int crossing_count;
    int switch_count;

    // Stimulus bookkeeping and the current idling pattern, in percent of cycles.
    int sent          = 0;
    int settings_done = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 49;
    int quiet_cycles  = 0;

    always #1 clk = ~clk;

    ac_burst_and_phase_power_control_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The checker watches all three channels, keeps its own model of the
    // controller and compares every output transaction against it.
    ac_burst_and_phase_power_control_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (fail_count),
        .outstanding    (outstanding),
        .event_count    (event_count),
        .crossing_count (crossing_count),
        .switch_count   (switch_count)
    );

    // The receiver drops tready at random according to the current pattern.
    // A new decision is made every cycle, so stalls land on every phase of
    // the mains cycle, including the cycle right after a zero crossing.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: any accepted transaction on any channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles, %0d results outstanding",
                     quiet_cycles, outstanding);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic acpc_pkg::acpc_event_t ev_of(input logic cmd, input int unsigned pct,
                                                    input int unsigned lim);
        acpc_pkg::acpc_event_t ev;
        ev.command         = cmd;
        ev.heater_percent  = pct[acpc_pkg::PERCENT_W-1:0];
        ev.fan_phase_limit = lim[acpc_pkg::LIMIT_W-1:0];
        return ev;
    endfunction

    // Offers one event and returns at the clock edge where it was accepted.
    // Before offering, the sender may sit idle, choosing anew at random in each
    // cycle; tvalid is only lowered then, so back-to-back events keep it high.
    task automatic send_event(input acpc_pkg::acpc_event_t ev);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.command;
        s_tdata  <= {{(acpc_pkg::S_TDATA_W - acpc_pkg::PERCENT_W - acpc_pkg::LIMIT_W){1'b0}},
                     ev.fan_phase_limit, ev.heater_percent};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // Leaves cfg_valid high on return so that a second write can follow in the
    // next cycle without a second assignment in the same time step.
    task automatic write_reg(input logic [acpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [acpc_pkg::DELAY_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(input logic [acpc_pkg::DELAY_W-1:0] delay,
                             input logic [acpc_pkg::ROT_W-1:0] rot);
        write_reg(acpc_pkg::CFG_SWITCH_DELAY, delay);
        write_reg(acpc_pkg::CFG_ROTATION, acpc_pkg::DELAY_W'(rot));
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Stops offering events and waits until every expected result has been
    // read. The count from the checker is updated after each edge, so the task
    // first waits for an edge to see the transaction accepted just now.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial begin
        int                           phase_end;
        int                           run;
        int unsigned                  d;
        logic [acpc_pkg::ROT_W-1:0]   rot;
        int unsigned                  lim;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset settings: no switch delay and two
        // channels in rotation, so zero crossings alternate heater and fan.
        // Ticks with the fan limit at zero and above the wrap value.
        send_event(ev_of(acpc_pkg::CMD_TICK, 127, 0));
        send_event(ev_of(acpc_pkg::CMD_TICK, 0, 127));
        send_event(ev_of(acpc_pkg::CMD_TICK, 0, 1));
        // Heater turn with a full 100 percent: one full on-cycle.
        send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS, 100, 127));
        send_event(ev_of(acpc_pkg::CMD_TICK, 0, 90));
        send_event(ev_of(acpc_pkg::CMD_TICK, 127, 90));
        // Fan turn: only the phase counter clears, the levels stay.
        send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS, 127, 0));
        send_event(ev_of(acpc_pkg::CMD_TICK, 0, 0));
        // Heater turn at zero percent marks a skipped cycle.
        send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS, 0, 127));
        send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS, 127, 127));
        // Percent above 100 is added as given and reduced once.
        send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS, 127, 0));
        send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS, 50, 90));
        send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS, 0, 0));
        send_event(ev_of(acpc_pkg::CMD_TICK, 0, 127));
        send_event(ev_of(acpc_pkg::CMD_TICK, 127, 127));
        send_event(ev_of(acpc_pkg::CMD_TICK, 85, 42));
        send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS, 73, 5));
        // Accumulator lands exactly on 100.
        send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS, 73, 90));
        send_event(ev_of(acpc_pkg::CMD_TICK, 42, 91));
        send_event(ev_of(acpc_pkg::CMD_TICK, 85, 2));
        send_event(ev_of(acpc_pkg::CMD_TICK, 0, 2));

        // Random part in six phases, each with its own register settings. The
        // first two phases use the fast-sender/stalling-receiver pattern, the
        // next two the reverse, and the last two run with no idling at all.
        for (int p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: begin d = 0;                     rot = 2'd2; end
                1: begin d = 255;                   rot = 2'd1; end
                2: begin d = $urandom_range(1, 30); rot = 2'd0; end
                3: begin d = 3;                     rot = 2'd3; end
                4: begin d = $urandom_range(0, 60); rot = 2'($urandom_range(3)); end
                default: begin d = 1;               rot = 2'd2; end
            endcase
            configure(d[acpc_pkg::DELAY_W-1:0], rot);

            send_idle_pct = (p < 2) ? 7 : (p < 4) ? 49 : 0;
            recv_idle_pct = (p < 2) ? 49 : (p < 4) ? 7 : 0;

            // The longest delay needs runs of more than 256 ticks per mains
            // cycle before any heater switch can happen at all.
            phase_end = sent + ((p == 1) ? 250 : 40);
            while (sent < phase_end) begin
                if ($urandom_range(99) < 85) begin
                    // One mains half cycle: a zero crossing, then a run of
                    // ticks with one fan limit. Runs sometimes pass the phase
                    // wrap and usually pass the scheduled switch time.
                    send_event(ev_of(acpc_pkg::CMD_ZERO_CROSS,
                                     ($urandom_range(99) < 80) ? $urandom_range(100)
                                                               : $urandom_range(127),
                                     $urandom_range(127)));
                    lim = ($urandom_range(99) < 85) ? $urandom_range(95) : $urandom_range(127);
                    run = (p == 1) ? $urandom_range(240, 300) : $urandom_range(1, d + 120);
                    repeat (run)
                        send_event(ev_of(acpc_pkg::CMD_TICK, $urandom_range(127), lim));
                end else begin
                    // Noise: a few events of either kind, such as back-to-back
                    // zero crossings or stray ticks with changing limits.
                    repeat ($urandom_range(1, 4))
                        send_event(ev_of(1'($urandom_range(1)), $urandom_range(127),
                                         $urandom_range(127)));
                end
            end
        end
        settle();

        $display("Covered %0d events, %0d of them zero crossings, with %0d heater switch points,",
                 event_count, crossing_count, switch_count);
        $display("over %0d register settings and three sender/receiver idling patterns.",
                 settings_done + 1);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
